// File: rtl/token_hash_similarity_index_defines.svh
// Assertion macros for the checker file of the similarity index.
`ifndef TOKEN_HASH_SIMILARITY_INDEX_DEFINES_SVH
`define TOKEN_HASH_SIMILARITY_INDEX_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define THSI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("similarity index: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define THSI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("similarity index: next-cycle check failed");

`endif

// File: rtl/thsi_pkg.sv
// Shared types and constants of the token hash similarity index.
package thsi_pkg;

  // Item function codes.
  localparam logic [2:0] FUNC_IDX_BYTE = 3'd0;
  localparam logic [2:0] FUNC_IDX_END  = 3'd1;
  localparam logic [2:0] FUNC_QRY_BYTE = 3'd2;
  localparam logic [2:0] FUNC_QRY_END  = 3'd3;
  localparam logic [2:0] FUNC_REPORT   = 3'd4;

  // Configuration register indexes.
  localparam logic REG_DOC_COUNT = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam int          CNT_W       = 11;
  localparam logic [10:0] CNT_MAX     = 11'd2047;
  localparam int          THR_W       = 16;
  localparam int          DC_W        = 7;
  localparam logic [6:0]  DC_RESET    = 7'd64;
  localparam logic [5:0]  MAX_RESULTS = 6'd63;
  localparam int          UNI_W       = 13;
  localparam int          PT_W        = 28;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_IX_RD,
    S_IX_CHK,
    S_IX_INC,
    S_Q_RD,
    S_Q_CHK,
    S_Q_OVRD,
    S_Q_OVWR,
    S_R_SELF,
    S_R_SELFW,
    S_R_RD,
    S_R_CALC,
    S_R_CMP,
    S_R_END,
    S_V_CLR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic mod_step;
    logic clr_all_wr;
    logic clr_vis_wr;
    logic clr_inc;
    logic clr_rst;
    logic bkt_rd;
    logic bkt_mark;
    logic uq_rd_id;
    logic uq_inc_id;
    logic vis_set;
    logic ov_rd;
    logic ov_inc;
    logic r_init;
    logic self_lat;
    logic r_rd;
    logic r_calc;
    logic r_cmp;
    logic r_end;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_report;
    logic is_alnum_byte;
    logic is_close;
    logic is_query;
    logic id_ok;
    logic tok_open;
    logic mod_last;
    logic hit;
    logic visited;
    logic d_last;
    logic r_emit;
    logic out_free;
    logic clr_last_all;
    logic clr_last_vis;
  } dp_status_t;

endpackage

// File: rtl/thsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module thsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/thsi_datapath.sv
// Datapath: token hashing, bucket, visited-mark and counter memories, report scoring, output register.
module thsi_datapath import thsi_pkg::*; #(
  parameter int NUM_BUCKETS = 1024,
  parameter int HASH_BASE   = 31,
  parameter int MAX_DOCS    = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [2:0]       func,
  input  logic [5:0]       doc_id,
  input  logic [7:0]       char_byte,
  input  logic [DC_W-1:0]  doc_count,
  input  logic [THR_W-1:0] threshold,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [5:0]       match_id,
  output logic             found,
  output logic             last,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       sts
);

  localparam int HW    = $clog2(NUM_BUCKETS);
  localparam int DW    = $clog2(MAX_DOCS);
  localparam int CLR_N = (NUM_BUCKETS > MAX_DOCS) ? NUM_BUCKETS : MAX_DOCS;
  localparam int CW    = $clog2(CLR_N);
  localparam int BW    = $clog2(HASH_BASE + 1);
  localparam int PW    = (((HW + BW) > 8) ? (HW + BW) : 8) + 1;
  localparam int SW    = $clog2(PW);
  localparam int QW    = 2 * PW;
  localparam logic [HW:0]   NB_C  = (HW + 1)'(NUM_BUCKETS);
  localparam logic [PW-1:0] NB_P  = PW'(NUM_BUCKETS);
  localparam logic [PW-1:0] RECIP = PW'((64'd1 << PW) / 64'(NUM_BUCKETS));

  logic [HW-1:0]       hash;
  logic                tok_open;
  logic [HW-1:0]       bkt;
  logic [5:0]          id_q;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       quo;
  logic [SW-1:0]       stp;
  logic [MAX_DOCS-1:0] mask;
  logic [DW-1:0]       d;
  logic [CW-1:0]       clr_cnt;
  logic [CNT_W-1:0]    selfu;
  logic [PT_W-1:0]     prod_t;
  logic [CNT_W-1:0]    ov_q;
  logic                elig_q;
  logic [5:0]          pend;
  logic                pend_v;
  logic [5:0]          nmatch;

  logic                alnum;
  logic [7:0]          lc;
  logic [QW-1:0]       qprod;
  logic [HW:0]         rem_w;
  logic [HW-1:0]       rem_next;
  logic                id_in_ok;
  logic                id_q_ok;
  logic                clr_in_nb;
  logic                clr_in_md;
  logic                match;
  logic [UNI_W-1:0]    uni;
  logic                uni_pos;

  logic [MAX_DOCS-1:0] b_rdata;
  logic                b_we;
  logic [HW-1:0]       b_waddr;
  logic [MAX_DOCS-1:0] b_wdata;
  logic                v_rdata;
  logic                v_we;
  logic [HW-1:0]       v_waddr;
  logic [CNT_W-1:0]    u_rdata;
  logic                u_we;
  logic [DW-1:0]       u_waddr;
  logic [CNT_W-1:0]    u_wdata;
  logic                u_re;
  logic [DW-1:0]       u_raddr;
  logic [CNT_W-1:0]    o_rdata;
  logic                o_we;
  logic [DW-1:0]       o_waddr;
  logic [CNT_W-1:0]    o_wdata;
  logic                o_re;

  // Byte classification and lowercasing.
  always_comb begin
    alnum = char_byte inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
    lc    = (char_byte inside {[8'd65:8'd90]}) ? (char_byte + 8'd32) : char_byte;
  end

  // Bucket remainder of the hash product: a reciprocal multiply estimates the
  // quotient, which is low by at most one, so one conditional subtract fixes it.
  always_comb begin
    qprod = QW'(prod) * QW'(RECIP);
    rem_w = (HW + 1)'(prod - quo * NB_P);
    if (rem_w >= NB_C) begin
      rem_next = HW'(rem_w - NB_C);
    end else begin
      rem_next = rem_w[HW-1:0];
    end
  end

  assign id_in_ok  = {1'b0, doc_id} < DC_W'(MAX_DOCS);
  assign id_q_ok   = {1'b0, id_q} < DC_W'(MAX_DOCS);
  assign clr_in_nb = {1'b0, clr_cnt} < (CW + 1)'(NUM_BUCKETS);
  assign clr_in_md = {1'b0, clr_cnt} < (CW + 1)'(MAX_DOCS);

  // Token register and hash unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash     <= '0;
      tok_open <= 1'b0;
      stp      <= '0;
    end else if (cmd.take) begin
      stp <= '0;
      id_q <= doc_id;
      prod <= PW'(hash) * PW'(HASH_BASE) + PW'(lc);
      bkt  <= hash;
      if (sts.is_close || sts.is_report) begin
        hash     <= '0;
        tok_open <= 1'b0;
      end
    end else if (cmd.mod_step) begin
      quo <= qprod[QW-1:PW];
      stp <= stp + SW'(1);
      if (sts.mod_last) begin
        hash     <= rem_next;
        tok_open <= 1'b1;
      end
    end
  end

  // Sweep counter for memory clearing.
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_inc) begin
      clr_cnt <= clr_cnt + CW'(1);
    end
  end

  // Document walk counter and bucket mask.
  always_ff @(posedge clk) begin
    if (cmd.vis_set) begin
      mask <= b_rdata;
    end
    if (cmd.vis_set || cmd.r_init) begin
      d <= '0;
    end else if (cmd.ov_inc || cmd.r_cmp) begin
      d <= d + DW'(1);
    end
  end

  // Report scoring: union and threshold product.
  always_comb begin
    uni     = UNI_W'(u_rdata) + UNI_W'(selfu) - UNI_W'(o_rdata);
    uni_pos = !uni[UNI_W-1] && (uni != '0);
    match   = elig_q && ({1'b0, ov_q, 16'b0} > prod_t) && (nmatch != MAX_RESULTS);
  end

  always_ff @(posedge clk) begin
    if (cmd.self_lat) begin
      selfu <= id_q_ok ? u_rdata : '0;
    end
    if (cmd.r_calc) begin
      prod_t <= PT_W'(threshold) * PT_W'(uni[CNT_W:0]);
      ov_q   <= o_rdata;
      elig_q <= (DC_W'(d) < doc_count) && (DC_W'(d) != DC_W'(id_q)) && uni_pos;
    end
  end

  // Pending match, held back until it is known whether it is the last.
  always_ff @(posedge clk) begin
    if (rst || cmd.r_init) begin
      pend_v <= 1'b0;
      nmatch <= '0;
    end else if (cmd.r_cmp && match) begin
      pend_v <= 1'b1;
      nmatch <= nmatch + 6'd1;
    end
    if (cmd.r_cmp && match) begin
      pend <= 6'(d);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.r_cmp && match && pend_v) || cmd.r_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.r_cmp && match && pend_v) begin
      match_id <= pend;
      found    <= 1'b1;
      last     <= 1'b0;
    end else if (cmd.r_end) begin
      match_id <= pend_v ? pend : 6'd0;
      found    <= pend_v;
      last     <= 1'b1;
    end
  end

  // Bucket membership memory.
  assign b_we    = (cmd.clr_all_wr && clr_in_nb) || cmd.bkt_mark;
  assign b_waddr = cmd.bkt_mark ? bkt : clr_cnt[HW-1:0];
  assign b_wdata = cmd.bkt_mark ? (b_rdata | (MAX_DOCS'(1) << id_q[DW-1:0])) : '0;

  thsi_ram #(.WIDTH(MAX_DOCS), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (cmd.bkt_rd),
    .raddr (bkt),
    .rdata (b_rdata)
  );

  // Query visited marks.
  assign v_we    = (cmd.clr_all_wr && clr_in_nb) || cmd.clr_vis_wr || cmd.vis_set;
  assign v_waddr = cmd.vis_set ? bkt : clr_cnt[HW-1:0];

  thsi_ram #(.WIDTH(1), .DEPTH(NUM_BUCKETS)) u_visited_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (cmd.vis_set),
    .re    (cmd.bkt_rd),
    .raddr (bkt),
    .rdata (v_rdata)
  );

  // Distinct bucket counts per document.
  assign u_we    = (cmd.clr_all_wr && clr_in_md) || cmd.uq_inc_id;
  assign u_waddr = cmd.uq_inc_id ? id_q[DW-1:0] : clr_cnt[DW-1:0];
  assign u_wdata = !cmd.uq_inc_id ? '0 :
                   (u_rdata == CNT_MAX) ? u_rdata : (u_rdata + CNT_W'(1));
  assign u_re    = cmd.uq_rd_id || cmd.r_init || cmd.r_rd;
  assign u_raddr = cmd.r_rd ? d : id_q[DW-1:0];

  thsi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DOCS)) u_unique_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (u_re),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  // Overlap counters; the report walk zeroes each entry after reading it.
  assign o_we    = (cmd.clr_all_wr && clr_in_md) || (cmd.ov_inc && mask[d]) || cmd.r_calc;
  assign o_waddr = cmd.clr_all_wr ? clr_cnt[DW-1:0] : d;
  assign o_wdata = !cmd.ov_inc ? '0 :
                   (o_rdata == CNT_MAX) ? o_rdata : (o_rdata + CNT_W'(1));
  assign o_re    = cmd.ov_rd || cmd.r_rd;

  thsi_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DOCS)) u_overlap_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .re    (o_re),
    .raddr (d),
    .rdata (o_rdata)
  );

  // Status toward the controller.
  always_comb begin
    sts.is_report     = func == FUNC_REPORT;
    sts.is_alnum_byte = ((func == FUNC_IDX_BYTE) || (func == FUNC_QRY_BYTE)) && alnum;
    sts.is_close      = (((func == FUNC_IDX_BYTE) || (func == FUNC_QRY_BYTE)) && !alnum)
                        || (func == FUNC_IDX_END) || (func == FUNC_QRY_END);
    sts.is_query      = (func == FUNC_QRY_BYTE) || (func == FUNC_QRY_END);
    sts.id_ok         = id_in_ok;
    sts.tok_open      = tok_open;
    sts.mod_last      = stp == SW'(1);
    sts.hit           = b_rdata[id_q[DW-1:0]];
    sts.visited       = v_rdata;
    sts.d_last        = d == DW'(MAX_DOCS - 1);
    sts.r_emit        = match && pend_v;
    sts.out_free      = !out_valid || out_ready;
    sts.clr_last_all  = clr_cnt == CW'(CLR_N - 1);
    sts.clr_last_vis  = clr_cnt[HW-1:0] == HW'(NUM_BUCKETS - 1);
  end

endmodule

// File: rtl/thsi_controller.sv
// Controller state machine sequencing clearing, hashing, indexing, queries and reports.
module thsi_controller import thsi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clr_last_all) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_report) begin
            state_next = S_R_SELF;
          end else if (sts.is_alnum_byte) begin
            state_next = S_MOD;
          end else if (sts.is_close && sts.tok_open) begin
            if (sts.is_query) begin
              state_next = S_Q_RD;
            end else if (sts.id_ok) begin
              state_next = S_IX_RD;
            end
          end
        end
      end
      S_MOD: begin
        if (sts.mod_last) state_next = S_IDLE;
      end
      S_IX_RD:  state_next = S_IX_CHK;
      S_IX_CHK: state_next = sts.hit ? S_IDLE : S_IX_INC;
      S_IX_INC: state_next = S_IDLE;
      S_Q_RD:   state_next = S_Q_CHK;
      S_Q_CHK:  state_next = sts.visited ? S_IDLE : S_Q_OVRD;
      S_Q_OVRD: state_next = S_Q_OVWR;
      S_Q_OVWR: state_next = sts.d_last ? S_IDLE : S_Q_OVRD;
      S_R_SELF:  state_next = S_R_SELFW;
      S_R_SELFW: state_next = S_R_RD;
      S_R_RD:    state_next = S_R_CALC;
      S_R_CALC:  state_next = S_R_CMP;
      S_R_CMP: begin
        if (!sts.r_emit || sts.out_free) begin
          state_next = sts.d_last ? S_R_END : S_R_RD;
        end
      end
      S_R_END: begin
        if (sts.out_free) state_next = S_V_CLR;
      end
      S_V_CLR: begin
        if (sts.clr_last_vis) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_all_wr = 1'b1;
        cmd.clr_inc    = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_MOD:    cmd.mod_step = 1'b1;
      S_IX_RD:  cmd.bkt_rd = 1'b1;
      S_IX_CHK: begin
        cmd.bkt_mark = !sts.hit;
        cmd.uq_rd_id = !sts.hit;
      end
      S_IX_INC: cmd.uq_inc_id = 1'b1;
      S_Q_RD:   cmd.bkt_rd = 1'b1;
      S_Q_CHK:  cmd.vis_set = !sts.visited;
      S_Q_OVRD: cmd.ov_rd = 1'b1;
      S_Q_OVWR: cmd.ov_inc = 1'b1;
      S_R_SELF:  cmd.r_init = 1'b1;
      S_R_SELFW: cmd.self_lat = 1'b1;
      S_R_RD:    cmd.r_rd = 1'b1;
      S_R_CALC:  cmd.r_calc = 1'b1;
      S_R_CMP:   cmd.r_cmp = !sts.r_emit || sts.out_free;
      S_R_END: begin
        cmd.r_end   = sts.out_free;
        cmd.clr_rst = sts.out_free;
      end
      S_V_CLR: begin
        cmd.clr_vis_wr = 1'b1;
        cmd.clr_inc    = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/token_hash_similarity_index.sv
// Top level of the token hash similarity index: register port and core wiring.
//
// Input items (func, doc_id, char_byte) enter on in_valid/in_ready; results
// (match_id, found, last) leave on out_valid/out_ready from an output register.
// Items are taken one at a time; in_ready is high only while the block idles.
// Steps per item, in the controller sequence:
//   letter or digit byte: the accepting cycle, a reciprocal multiply for the
//     bucket quotient and a remainder correction that updates the hash;
//   index token end: one bucket read-modify-write and a count update;
//   query token end: a bucket check, then each overlap counter read and updated;
//   report: a walk that reads, scores and compares each document, the final
//     result, a sweep that clears the visited marks, and any receiver stalls.
// A report gives its matches in document order, last set on the final one, or
// a single result with found low when nothing matches.
// After reset the block clears all stores over max(NUM_BUCKETS, MAX_DOCS)
// addresses and takes no item meanwhile; register writes are taken at any time.
// A stalled receiver holds the report walk until the output register drains.
module token_hash_similarity_index import thsi_pkg::*; #(
  parameter int NUM_BUCKETS = 1024,
  parameter int HASH_BASE   = 31,
  parameter int MAX_DOCS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [5:0]  doc_id,
  input  logic [7:0]  char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  match_id,
  output logic        found,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [DC_W-1:0]  doc_count;
  logic [THR_W-1:0] threshold;
  ctrl_cmd_t        cmd;
  dp_status_t       sts;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      doc_count <= DC_RESET;
      threshold <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_DOC_COUNT: doc_count <= pwdata[DC_W-1:0];
        REG_THRESHOLD: threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[2])
      REG_DOC_COUNT: prdata = 32'(doc_count);
      REG_THRESHOLD: prdata = 32'(threshold);
      default:       prdata = '0;
    endcase
  end

  thsi_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  thsi_datapath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .HASH_BASE   (HASH_BASE),
    .MAX_DOCS    (MAX_DOCS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .doc_id    (doc_id),
    .char_byte (char_byte),
    .doc_count (doc_count),
    .threshold (threshold),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .match_id  (match_id),
    .found     (found),
    .last      (last),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: rtl/thsi_checker.sv
// Port-level checker for the similarity index and its bind statement.
`include "token_hash_similarity_index_defines.svh"

module thsi_checker import thsi_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] match_id,
  input logic       found,
  input logic       last
);

  // A stalled result item holds its value.
  `THSI_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(match_id) && $stable(found) && $stable(last))

  // The no-match result is always the last one and names document zero.
  `THSI_ASSERT_SAME(a_nomatch_form, clk, rst, out_valid && !found, last && (match_id == 6'd0))

  // A report keeps the input closed in the following cycle.
  `THSI_ASSERT_NEXT(a_report_busy, clk, rst, in_valid && in_ready && (func == FUNC_REPORT), !in_ready)

  // While a report still has results to give, no item is taken.
  `THSI_ASSERT_NEXT(a_report_open, clk, rst, out_valid && out_ready && !last, !in_ready)

endmodule

bind token_hash_similarity_index thsi_checker u_thsi_checker (.*);

// File: test/tb.sv
// Self-checking testbench for the token hash similarity index.
`timescale 1ns / 100ps

module tb;
  import thsi_pkg::*;

  typedef struct packed {
    logic [5:0] match_id;
    logic       found;
    logic       last;
  } match_t;

  // Tracks the index contents and predicts the result items of each report.
  class similarity_scoreboard;
    bit [63:0] members[1024];
    bit [10:0] uniq_cnt[64];
    bit [10:0] overlap[64];
    bit        visited[1024];
    bit [9:0]  tok_hash;
    bit        tok_open;
    bit [6:0]  doc_limit;
    bit [15:0] threshold;
    match_t    pending_q[$];
    int        errors;

    function new();
      foreach (members[i]) members[i] = '0;
      foreach (visited[i]) visited[i] = 1'b0;
      foreach (uniq_cnt[i]) uniq_cnt[i] = '0;
      foreach (overlap[i]) overlap[i] = '0;
      tok_hash = '0;
      tok_open = 1'b0;
      doc_limit = DC_RESET;
      threshold = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, bit [31:0] value);
      if (idx == REG_DOC_COUNT) doc_limit = value[6:0];
      else threshold = value[15:0];
    endfunction

    function bit is_word_char(bit [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function void close_index(bit [5:0] id);
      if (tok_open && !members[tok_hash][id]) begin
        members[tok_hash][id] = 1'b1;
        if (uniq_cnt[id] != CNT_MAX) uniq_cnt[id]++;
      end
      tok_open = 1'b0;
      tok_hash = '0;
    endfunction

    function void close_query();
      if (tok_open && !visited[tok_hash]) begin
        visited[tok_hash] = 1'b1;
        for (int i = 0; i < 64; i++)
          if (members[tok_hash][i] && overlap[i] != CNT_MAX) overlap[i]++;
      end
      tok_open = 1'b0;
      tok_hash = '0;
    endfunction

    // Applies one accepted item and queues the results it causes.
    function void note_item(bit [2:0] fn, bit [5:0] id, bit [7:0] c);
      int unsigned scan;
      longint self_u, uni, ov;
      match_t m;
      int n;
      n = 0;
      if (fn == FUNC_IDX_BYTE || fn == FUNC_QRY_BYTE) begin
        if (is_word_char(c)) begin
          if (c >= "A" && c <= "Z") c = c + 8'd32;
          tok_hash = 10'((31 * int'(tok_hash) + int'(c)) % 1024);
          tok_open = 1'b1;
        end else if (fn == FUNC_QRY_BYTE) close_query();
        else close_index(id);
      end else if (fn == FUNC_IDX_END) close_index(id);
      else if (fn == FUNC_QRY_END) close_query();
      else if (fn == FUNC_REPORT) begin
        scan = (doc_limit > 64) ? 64 : doc_limit;
        self_u = uniq_cnt[id];
        for (int i = 0; i < scan; i++) begin
          ov = overlap[i];
          uni = longint'(uniq_cnt[i]) + self_u - ov;
          if (i != id && uni > 0 && ov * 65536 > longint'(threshold) * uni && n < 63) begin
            m.match_id = 6'(i);
            m.found = 1'b1;
            m.last = 1'b0;
            pending_q.push_back(m);
            n++;
          end
        end
        if (n == 0) begin
          m = '{match_id: 6'd0, found: 1'b0, last: 1'b1};
          pending_q.push_back(m);
        end else begin
          pending_q[pending_q.size() - 1].last = 1'b1;
        end
        foreach (visited[i]) visited[i] = 1'b0;
        foreach (overlap[i]) overlap[i] = '0;
        tok_hash = '0;
        tok_open = 1'b0;
      end
    endfunction

    // Compares one result item with the oldest prediction.
    function void check_result(logic [5:0] mid, logic fd, logic lst);
      match_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result item: match_id %0d found %0d last %0d", mid, fd, lst);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (mid !== e.match_id) begin
        $error("match_id: expected %0d, actual %0d", e.match_id, mid);
        errors++;
      end
      if (fd !== e.found) begin
        $error("found: expected %0d, actual %0d", e.found, fd);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic [2:0]  func;
  logic [5:0]  doc_id;
  logic [7:0]  char_byte;
  logic        out_valid, out_ready;
  logic [5:0]  match_id;
  logic        found, last;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  similarity_scoreboard sb = new();
  int item_count;
  string vocab[12] = '{"alpha", "Beta", "gamma9", "DELTA", "x", "42", "zeta", "Omega",
                       "rho", "k7z", "nu", "tau"};

  token_hash_similarity_index dut (.*);

  always #6 clk = ~clk;

  // Random receiver stalls, mostly short with an occasional long one.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 10) begin
      stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(match_id, found, last);

  // Sends one item after a random gap and waits for its acceptance.
  task automatic send_item(bit [2:0] fn, bit [5:0] id, bit [7:0] c);
    int r, gap;
    r = $urandom_range(0, 19);
    gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    doc_id <= id;
    char_byte <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_item(fn, id, c);
    item_count++;
  endtask

  task automatic reg_write(logic idx, bit [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Waits for all predicted results, then lets the block finish clearing.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  // Sends one word with random letter case, then a separator or field end.
  task automatic send_word(bit query, string w, bit [5:0] id);
    bit [7:0] c;
    bit [2:0] byte_fn;
    byte_fn = query ? FUNC_QRY_BYTE : FUNC_IDX_BYTE;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1))
        c = c ^ 8'h20;
      send_item(byte_fn, id, c);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(query ? FUNC_QRY_END : FUNC_IDX_END, id, 8'($urandom));
    end else begin
      do c = 8'($urandom); while (sb.is_word_char(c));
      send_item(byte_fn, id, c);
    end
  endtask

  initial begin
    bit [5:0] ids[4];
    bit [5:0] qid;
    int n_docs;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= '0;
    doc_id <= '0;
    char_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    out_ready <= 1'b0;
    item_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: case folding, digits, shared buckets, unused codes, no match.
    send_item(FUNC_IDX_BYTE, 6'd0, "A");
    send_item(FUNC_IDX_BYTE, 6'd0, "b");
    send_item(FUNC_IDX_BYTE, 6'd0, "1");
    send_item(FUNC_IDX_BYTE, 6'd0, 8'h00);
    send_item(FUNC_IDX_BYTE, 6'd0, "Z");
    send_item(FUNC_IDX_END, 6'd0, 8'hFF);
    send_item(FUNC_IDX_BYTE, 6'd63, "a");
    send_item(FUNC_IDX_BYTE, 6'd63, "B");
    send_item(FUNC_IDX_BYTE, 6'd63, "1");
    send_item(FUNC_IDX_END, 6'd63, 8'h00);
    send_item(FUNC_IDX_END, 6'd63, 8'h20);
    send_item(3'd5, 6'd63, "q");
    send_item(3'd6, 6'd1, 8'hFF);
    send_item(3'd7, 6'd2, "9");
    send_item(FUNC_QRY_BYTE, 6'd0, "a");
    send_item(FUNC_QRY_BYTE, 6'd0, "b");
    send_item(FUNC_QRY_BYTE, 6'd0, "1");
    send_item(FUNC_QRY_END, 6'd0, 8'h00);
    send_item(FUNC_QRY_END, 6'd0, 8'h00);
    send_item(FUNC_REPORT, 6'd0, 8'h00);
    send_item(FUNC_QRY_BYTE, 6'd0, "z");
    send_item(FUNC_REPORT, 6'd5, 8'h00);
    drain();
    reg_write(REG_THRESHOLD, 32'd65535);
    reg_write(REG_DOC_COUNT, 32'd127);
    send_item(FUNC_REPORT, 6'd63, 8'h00);

    // Random part: index a few documents, query one, report, now and then retune.
    while (item_count < 360) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        case ($urandom_range(0, 4))
          0: reg_write(REG_DOC_COUNT, 32'd0);
          1: reg_write(REG_DOC_COUNT, 32'd1);
          2: reg_write(REG_DOC_COUNT, 32'd64);
          3: reg_write(REG_DOC_COUNT, 32'd127);
          default: reg_write(REG_DOC_COUNT, $urandom_range(1, 127));
        endcase
        case ($urandom_range(0, 4))
          0: reg_write(REG_THRESHOLD, 32'd0);
          1: reg_write(REG_THRESHOLD, 32'd65535);
          2: reg_write(REG_THRESHOLD, 32'd32768);
          default: reg_write(REG_THRESHOLD, $urandom_range(0, 65535));
        endcase
      end
      n_docs = $urandom_range(1, 3);
      for (int d = 0; d < n_docs; d++) begin
        ids[d] = ($urandom_range(0, 1)) ? 6'($urandom_range(0, 7)) : 6'($urandom);
        repeat ($urandom_range(1, 4)) send_word(1'b0, vocab[$urandom_range(0, 11)], ids[d]);
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 6))
          send_item(3'($urandom), 6'($urandom), 8'($urandom));
      qid = ($urandom_range(0, 1)) ? ids[0] : 6'($urandom);
      repeat ($urandom_range(0, 4)) send_word(1'b1, vocab[$urandom_range(0, 11)], qid);
      if ($urandom_range(0, 4) == 0) send_item(FUNC_QRY_BYTE, qid, "m");
      send_item(FUNC_REPORT, qid, 8'($urandom));
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #30000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
